// ===== rtl/hpcm_pkg.sv =====
package hpcm_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  client_id;
    logic [9:0]  ocf;
    logic [5:0]  ogf;
    logic        reply_kind;
    logic [7:0]  evt_code;
    logic [7:0]  param_length;
    logic [7:0]  event_credits;
    logic [15:0] event_opcode;
    logic [7:0]  event_status;
  } in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [2:0]  slot;
    logic [1:0]  owner;
    logic [15:0] command_opcode;
    logic        matched_kind;
    logic [7:0]  reply_status;
    logic [7:0]  credits;
    logic [3:0]  pending;
  } out_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic        reply_kind;
    logic [1:0]  owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } cmd_t;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_EVT = 2'd1;
  localparam logic [1:0] KIND_REL = 2'd2;

  localparam logic [2:0] OUT_ACCEPTED = 3'd0;
  localparam logic [2:0] OUT_DUP      = 3'd1;
  localparam logic [2:0] OUT_FULL     = 3'd2;
  localparam logic [2:0] OUT_MATCHED  = 3'd3;
  localparam logic [2:0] OUT_NOMATCH  = 3'd4;
  localparam logic [2:0] OUT_RELEASED = 3'd5;

  localparam logic [7:0] EV_COMPLETE = 8'h0E;
  localparam logic [7:0] EV_STATUS   = 8'h0F;
  localparam logic [7:0] MIN_CPLT_LEN = 8'd3;

  localparam logic [7:0]  REPLY_COMPLETE = 8'd0;
  localparam logic        RK_COMPLETE = 1'b0;
  localparam logic        RK_STATUS   = 1'b1;

endpackage

// ===== rtl/hpcm_ram.sv =====
module hpcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hpcm_ctrl.sv =====
module hpcm_ctrl import hpcm_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          out_free,
  output cmd_t          cmd,
  output logic [IW-1:0] rd_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t        state_r;
  logic [IW-1:0] idx_r;
  logic          last_idx;

  assign last_idx = (idx_r == IW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_idx) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.rd_en  = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && out_free;
  assign rd_addr    = idx_r;

endmodule

// ===== rtl/hpcm_datapath.sv =====
module hpcm_datapath import hpcm_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_t           in_data,
  input  cmd_t          cmd,
  input  logic [IW-1:0] rd_addr,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data
);

  localparam int CW = $clog2(SLOTS + 1);

  in_t           item_r;
  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0] count_r;
  logic [7:0]    credits_r;

  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          hit_found_r;
  logic [IW-1:0] hit_idx_r;
  entry_t        hit_ent_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;

  logic          out_valid_r;
  out_t          out_data_r;

  entry_t        rd_ent;
  logic [ENTRY_W-1:0] rd_bits;
  entry_t        wr_ent;

  logic [15:0]   reg_opcode;
  logic          evt_cplt;
  logic          evt_stat;
  logic          search_en;
  logic          search_kind;
  logic [15:0]   search_opcode;
  logic          slot_valid;
  logic          hit;
  logic          rel_hit;

  out_t          res;
  logic          emit;
  logic          do_alloc;
  logic          do_free;
  logic          credit_upd;
  logic [CW-1:0] count_cm;

  // item decode
  assign reg_opcode = {item_r.ogf, item_r.ocf};
  assign evt_cplt   = (item_r.evt_code == EV_COMPLETE);
  assign evt_stat   = (item_r.evt_code == EV_STATUS);

  always_comb begin
    search_en     = 1'b0;
    search_kind   = RK_COMPLETE;
    search_opcode = item_r.event_opcode;
    unique case (item_r.kind)
      KIND_REG: begin
        search_en     = 1'b1;
        search_kind   = item_r.reply_kind;
        search_opcode = reg_opcode;
      end
      KIND_EVT: begin
        search_en   = (evt_cplt && (item_r.param_length >= MIN_CPLT_LEN)) || evt_stat;
        search_kind = evt_stat ? RK_STATUS : RK_COMPLETE;
      end
      default: begin
        search_en = 1'b0;
      end
    endcase
  end

  // slot scan, one entry per beat of the read port
  assign rd_ent     = entry_t'(rd_bits);
  assign slot_valid = cmp_vld_r && valid_r[cmp_idx_r];
  assign hit        = slot_valid && search_en && (rd_ent.reply_kind == search_kind) &&
                      (rd_ent.opcode == search_opcode);
  assign rel_hit    = slot_valid && (item_r.kind == KIND_REL) &&
                      (rd_ent.owner == item_r.client_id);

  hpcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && do_alloc),
    .waddr (free_idx_r),
    .wdata (wr_ent),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign wr_ent.opcode     = reg_opcode;
  assign wr_ent.reply_kind = item_r.reply_kind;
  assign wr_ent.owner      = item_r.client_id;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    cmp_idx_r <= rd_addr;
    if (hit && !hit_found_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_ent_r <= rd_ent;
    end
    if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.commit && emit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (hit) begin
          hit_found_r <= 1'b1;
        end
        if (cmp_vld_r && !valid_r[cmp_idx_r]) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  // result and table update
  always_comb begin
    res        = '0;
    emit       = 1'b1;
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    credit_upd = 1'b0;
    unique case (item_r.kind)
      KIND_REG: begin
        res.command_opcode = reg_opcode;
        if (count_r >= CW'(SLOTS)) begin
          res.outcome = OUT_FULL;
        end else if (hit_found_r) begin
          res.outcome = OUT_DUP;
        end else if (free_found_r) begin
          res.outcome = OUT_ACCEPTED;
          res.slot    = 3'(free_idx_r);
          do_alloc    = 1'b1;
        end else begin
          res.outcome = OUT_FULL;
        end
      end
      KIND_EVT: begin
        credit_upd = evt_cplt || evt_stat;
        if (hit_found_r) begin
          res.outcome        = OUT_MATCHED;
          res.slot           = 3'(hit_idx_r);
          res.owner          = hit_ent_r.owner;
          res.command_opcode = hit_ent_r.opcode;
          res.matched_kind   = hit_ent_r.reply_kind;
          res.reply_status   = evt_stat ? item_r.event_status : REPLY_COMPLETE;
          do_free            = 1'b1;
        end else begin
          res.outcome = OUT_NOMATCH;
        end
      end
      KIND_REL: begin
        res.outcome = OUT_RELEASED;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (do_alloc) begin
      count_cm = count_r + CW'(1);
    end else if (do_free) begin
      count_cm = count_r - CW'(1);
    end else begin
      count_cm = count_r;
    end
    res.credits = credit_upd ? item_r.event_credits : credits_r;
    res.pending = 4'(count_cm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      credits_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rel_hit) begin
        valid_r[cmp_idx_r] <= 1'b0;
        count_r            <= count_r - CW'(1);
      end
      if (cmd.commit) begin
        count_r <= count_cm;
        if (do_alloc) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (do_free) begin
          valid_r[hit_idx_r] <= 1'b0;
        end
        if (credit_upd) begin
          credits_r <= item_r.event_credits;
        end
        out_valid_r <= emit;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/hci_pending_command_matcher_unit.sv =====
// Pending HCI command table with SLOTS entries. A register beat claims the lowest free
// slot unless the table is full or the same opcode and reply kind is already pending; an
// event beat with a complete or status code updates the command credits and retires the
// lowest matching slot; a release beat frees every slot of one client. A beat is taken in
// the idle state; the scan state then reads the table RAM one slot per cycle, the drain
// state compares the last slot, and the commit state updates the table and loads the
// result register. The commit state waits for as long as an earlier result is still held
// in the output register by out_stall. A finished result waits in the output register
// while the next beat is accepted and scanned; kind 3 beats are taken and give no result.
module hci_pending_command_matcher_unit import hpcm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t          cmd;
  logic [IW-1:0] rd_addr;
  logic          out_free;

  hpcm_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  hpcm_datapath #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/hpcm_checker.sv =====
module hpcm_checker import hpcm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one beat in the table at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted during scan");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SLOTS >= 16) || (out_data.pending <= SLOTS))
    else $error("pending count above table size");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.outcome <= OUT_RELEASED)
    else $error("outcome code out of range");

  a_claim_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OUT_ACCEPTED) |->
      (out_data.pending != 4'd0) && ((SLOTS >= 8) || (out_data.slot < SLOTS)))
    else $error("claimed slot inconsistent with table");

endmodule

bind hci_pending_command_matcher_unit hpcm_checker #(.SLOTS(SLOTS)) u_hpcm_checker (.*);

// ===== tb/sv/hci_pending_command_matcher_unit_tb.sv =====
module hci_pending_command_matcher_unit_tb import hpcm_pkg::*;;

  localparam int SLOTS = 8;
  localparam int ITEMS = 700;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_N = 12;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class cmd_table_scoreboard;
    bit          occ[SLOTS];
    logic [15:0] op_tab[SLOTS];
    logic        rk_tab[SLOTS];
    logic [1:0]  own_tab[SLOTS];
    int unsigned busy;
    logic [7:0]  credit;
    out_t        awaited_replies[$];
    int unsigned errors;
    int unsigned n_reg, n_evt, n_rel, n_unused;
    int unsigned n_checked, n_match, n_dup, n_full, n_released;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occ[i] = 1'b0;
        op_tab[i] = '0;
        rk_tab[i] = 1'b0;
        own_tab[i] = '0;
      end
      busy = 0;
      credit = '0;
      errors = 0;
      n_reg = 0; n_evt = 0; n_rel = 0; n_unused = 0;
      n_checked = 0; n_match = 0; n_dup = 0; n_full = 0; n_released = 0;
    endfunction

    function int lookup(logic rk, logic [15:0] op);
      for (int i = 0; i < SLOTS; i++) begin
        if (occ[i] && rk_tab[i] == rk && op_tab[i] == op) return i;
      end
      return -1;
    endfunction

    // work out the reply to one accepted request and update the table copy
    function void log_request(in_t b);
      out_t        r;
      logic [15:0] op;
      int          hit;
      int          fr;
      bit          stat;
      r = '0;
      hit = -1;
      fr = -1;
      stat = 1'b0;
      case (b.kind)
        KIND_REG: begin
          n_reg++;
          op = {b.ogf, b.ocf};
          r.command_opcode = op;
          if (busy >= SLOTS) begin
            r.outcome = OUT_FULL;
          end else if (lookup(b.reply_kind, op) >= 0) begin
            r.outcome = OUT_DUP;
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
              if (!occ[i]) fr = i;
            end
            if (fr < 0) begin
              r.outcome = OUT_FULL;
            end else begin
              occ[fr] = 1'b1;
              op_tab[fr] = op;
              rk_tab[fr] = b.reply_kind;
              own_tab[fr] = b.client_id;
              busy++;
              r.outcome = OUT_ACCEPTED;
              r.slot = fr[2:0];
            end
          end
        end
        KIND_EVT: begin
          n_evt++;
          if (b.evt_code == EV_COMPLETE) begin
            credit = b.event_credits;
            if (b.param_length >= MIN_CPLT_LEN) hit = lookup(RK_COMPLETE, b.event_opcode);
          end else if (b.evt_code == EV_STATUS) begin
            credit = b.event_credits;
            stat = 1'b1;
            hit = lookup(RK_STATUS, b.event_opcode);
          end
          if (hit >= 0) begin
            r.outcome = OUT_MATCHED;
            r.slot = hit[2:0];
            r.owner = own_tab[hit];
            r.command_opcode = op_tab[hit];
            r.matched_kind = rk_tab[hit];
            r.reply_status = stat ? b.event_status : REPLY_COMPLETE;
            occ[hit] = 1'b0;
            if (busy > 0) busy--;
          end else begin
            r.outcome = OUT_NOMATCH;
          end
        end
        KIND_REL: begin
          n_rel++;
          for (int i = 0; i < SLOTS; i++) begin
            if (occ[i] && own_tab[i] == b.client_id) begin
              occ[i] = 1'b0;
              if (busy > 0) busy--;
            end
          end
          r.outcome = OUT_RELEASED;
        end
        default: begin
          n_unused++;
          return;
        end
      endcase
      r.credits = credit;
      r.pending = busy[3:0];
      awaited_replies.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_reply(out_t got);
      out_t e;
      if (awaited_replies.size() == 0) begin
        $error("reply beat with none awaited: %0h", got);
        errors++;
        return;
      end
      e = awaited_replies.pop_front();
      n_checked++;
      case (e.outcome)
        OUT_MATCHED:  n_match++;
        OUT_DUP:      n_dup++;
        OUT_FULL:     n_full++;
        OUT_RELEASED: n_released++;
        default: ;
      endcase
      cmp("outcome", 16'(e.outcome), 16'(got.outcome));
      cmp("slot", 16'(e.slot), 16'(got.slot));
      cmp("owner", 16'(e.owner), 16'(got.owner));
      cmp("command_opcode", e.command_opcode, got.command_opcode);
      cmp("matched_kind", 16'(e.matched_kind), 16'(got.matched_kind));
      cmp("reply_status", 16'(e.reply_status), 16'(got.reply_status));
      cmp("credits", 16'(e.credits), 16'(got.credits));
      cmp("pending", 16'(e.pending), 16'(got.pending));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  cmd_table_scoreboard sb;
  logic [15:0] op_pool[POOL_N];
  int unsigned quiet_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  hci_pending_command_matcher_unit #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // reply side: check, stall pattern and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_reply(out_data);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hci_pending_command_matcher_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_t mk_reg(logic [1:0] client, logic [9:0] ocf, logic [5:0] ogf,
                                 logic rk);
    in_t it;
    it.kind = KIND_REG;
    it.client_id = client;
    it.ocf = ocf;
    it.ogf = ogf;
    it.reply_kind = rk;
    it.evt_code = 8'($urandom);
    it.param_length = 8'($urandom);
    it.event_credits = 8'($urandom);
    it.event_opcode = 16'($urandom);
    it.event_status = 8'($urandom);
    return it;
  endfunction

  function automatic in_t mk_evt(logic [7:0] code, logic [7:0] plen, logic [7:0] cred,
                                 logic [15:0] op, logic [7:0] status);
    in_t it;
    it.kind = KIND_EVT;
    it.client_id = 2'($urandom);
    it.ocf = 10'($urandom);
    it.ogf = 6'($urandom);
    it.reply_kind = 1'($urandom);
    it.evt_code = code;
    it.param_length = plen;
    it.event_credits = cred;
    it.event_opcode = op;
    it.event_status = status;
    return it;
  endfunction

  function automatic in_t mk_rel(logic [1:0] client);
    in_t it;
    it = mk_reg(client, 10'($urandom), 6'($urandom), 1'($urandom));
    it.kind = KIND_REL;
    return it;
  endfunction

  function automatic in_t rand_request();
    in_t         it;
    int unsigned r;
    logic [15:0] op;
    logic [7:0]  code;
    logic [7:0]  plen;
    r = $urandom_range(0, 99);
    op = ($urandom_range(0, 3) == 0) ? 16'($urandom) : op_pool[$urandom_range(0, POOL_N - 1)];
    if (r < 46) begin
      it = mk_reg(2'($urandom), op[9:0], op[15:10], 1'($urandom));
    end else if (r < 90) begin
      r = $urandom_range(0, 99);
      code = (r < 45) ? EV_COMPLETE : (r < 85) ? EV_STATUS : 8'($urandom);
      plen = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 255));
      it = mk_evt(code, plen, 8'($urandom), op, 8'($urandom));
    end else begin
      it = mk_rel(2'($urandom));
    end
    return it;
  endfunction

  task automatic send(in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.log_request(it);
  endtask

  task automatic idle(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send(mk_evt(EV_STATUS, 8'd4, 8'hFF, 16'h1234, 8'h00));
    send(mk_reg(2'd0, 10'd0, 6'd0, RK_COMPLETE));
    send(mk_reg(2'd3, 10'h3FF, 6'h3F, RK_STATUS));
    send(mk_reg(2'd3, 10'h3FF, 6'h3F, RK_STATUS));
    send(mk_reg(2'd2, 10'h3FF, 6'h3F, RK_COMPLETE));
    send(mk_reg(2'd1, 10'h003, 6'h03, RK_COMPLETE));
    send(mk_reg(2'd2, 10'h005, 6'h01, RK_STATUS));
    send(mk_reg(2'd3, 10'h2AA, 6'h15, RK_COMPLETE));
    send(mk_reg(2'd0, 10'h155, 6'h2A, RK_STATUS));
    send(mk_reg(2'd1, 10'h001, 6'h04, RK_COMPLETE));
    send(mk_reg(2'd2, 10'h010, 6'h08, RK_COMPLETE));
    send(mk_evt(EV_COMPLETE, 8'd2, 8'h00, 16'h0000, 8'hFF));
    send(mk_evt(EV_COMPLETE, 8'd3, 8'h07, 16'h0000, 8'hFF));
    send(mk_evt(EV_STATUS, 8'd0, 8'h01, 16'hFFFF, 8'hA5));
    send(mk_evt(8'h3E, 8'd255, 8'h55, 16'hFFFF, 8'h12));
    send(mk_evt(EV_COMPLETE, 8'd255, 8'h80, 16'hFFFF, 8'h00));
    send('1);
    send(mk_rel(2'd3));
    send(mk_rel(2'd3));
    send(mk_reg(2'd3, 10'd0, 6'd0, RK_STATUS));
    send(mk_rel(2'd1));
    send(mk_rel(2'd2));
    send(mk_rel(2'd0));
    send(mk_rel(2'd3));
  endtask

  initial begin
    int unsigned done;
    int unsigned burst_left;
    in_t         it;
    sb = new();
    for (int i = 0; i < POOL_N; i++) op_pool[i] = 16'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_drained();
    done = 0;
    burst_left = 0;
    while (done < ITEMS) begin
      if (burst_left == 0) begin
        idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
      if ($urandom_range(0, 19) == 0) op_pool[$urandom_range(0, POOL_N - 1)] = 16'($urandom);
      if ($urandom_range(0, 39) == 0) begin
        it = '1;
        it.client_id = 2'($urandom);
        it.event_opcode = 16'($urandom);
        it.kind = KIND_UNUSED;
        send(it);
      end else begin
        send(rand_request());
        done++;
      end
      burst_left--;
      if (done == ITEMS / 2) wait_drained();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.awaited_replies.size() != 0) begin
      $error("%0d replies never arrived", sb.awaited_replies.size());
      sb.errors++;
    end
    $display("covered %0d beats: %0d register, %0d event, %0d release, %0d unused kind",
             sb.n_reg + sb.n_evt + sb.n_rel + sb.n_unused, sb.n_reg, sb.n_evt, sb.n_rel,
             sb.n_unused);
    $display("checked %0d replies: %0d matched, %0d duplicate, %0d table full, %0d released",
             sb.n_checked, sb.n_match, sb.n_dup, sb.n_full, sb.n_released);
    if (sb.errors == 0) begin
      $display("hci_pending_command_matcher_unit regression: pass");
    end else begin
      $display("hci_pending_command_matcher_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpcm_pkg.sv
rtl/hpcm_ram.sv
rtl/hpcm_ctrl.sv
rtl/hpcm_datapath.sv
rtl/hci_pending_command_matcher_unit.sv
rtl/hpcm_checker.sv
tb/sv/hci_pending_command_matcher_unit_tb.sv
